// File: design/fwk_pkg.sv
// Shared types, constants and helpers for the appendable Fenwick tree.
package fwk_pkg;

   localparam int CAPACITY   = 1024;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = 11;
   localparam int DATA_W     = 64;
   localparam int STAT_W     = 2;
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam logic MODE_APPEND = 1'b0;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_NOP    = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [DATA_W-1:0]  value;
      logic [ADDR_W-1:0]  slot;
      logic [CNT_W-1:0]   lo_index;
      logic [CNT_W-1:0]   hi_index;
      status_type         status;
      logic [CNT_W-1:0]   count;
   } cmd_type;

   function automatic logic [CNT_W-1:0] lowbit(input logic [CNT_W-1:0] x);
      return x & (~x + CNT_W'(1));
   endfunction

endpackage

// File: design/fenwick_append_range_sum.sv
// Appendable Fenwick tree with 64-bit wrapping range sums.
// Append beats store a new node built from the value and its child nodes; query beats return
// the sum of elements in [low_index, high_index), negated when low exceeds high. Each item
// yields exactly one result beat. The front end classifies items against the element count and
// hands them through a two-entry command queue to a walker that reads the single-port tree
// memory once per cycle. An append reads its child nodes in turn and then writes the new node; a
// query adds the nodes of the high_index prefix and then subtracts those of the low_index prefix;
// refused items go straight to the result. The request side keeps accepting until the command
// queue fills, and one finished result is held for the consumer while the walker moves on. No
// clearing pass is needed after reset.
module fenwick_append_range_sum import fwk_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic                     req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [CNT_W-1:0]         req_low_index,
   input  logic [CNT_W-1:0]         req_high_index,
   output logic                     empty,
   input  logic                     pop,
   output logic signed [DATA_W-1:0] rsp_range_sum,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [CNT_W-1:0]         rsp_element_count
);

   logic    cmd_push;
   cmd_type cmd_data;
   logic    cmd_full;
   cmd_type cmd_head;
   logic    cmd_valid;
   logic    cmd_pop;

   fwk_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (push),
      .req_full       (full),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_low_index  (req_low_index),
      .req_high_index (req_high_index),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_data),
      .cmd_full       (cmd_full)
   );

   fwk_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .not_empty (cmd_valid)
   );

   fwk_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_head          (cmd_head),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_range_sum     (rsp_range_sum),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

endmodule

// File: design/fwk_front.sv
// Front end: accepts request beats, tracks the element count and classifies each item.
module fwk_front import fwk_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [CNT_W-1:0]         req_low_index,
   input  logic [CNT_W-1:0]         req_high_index,
   output logic                     cmd_push,
   output cmd_type                  cmd_data,
   input  logic                     cmd_full
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             at_capacity;
   logic             grows;

   assign req_full    = cmd_full;
   assign cmd_push    = req_push && !cmd_full;
   assign at_capacity = (count_ff == CNT_W'(CAPACITY));
   assign grows       = cmd_push && (req_mode == MODE_APPEND) && !at_capacity;
   assign count_in    = grows ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      cmd_data          = '0;
      cmd_data.value    = req_value;
      cmd_data.slot     = count_ff[ADDR_W-1:0];
      cmd_data.lo_index = req_low_index;
      cmd_data.hi_index = req_high_index;
      cmd_data.count    = count_in;
      if (req_mode == MODE_APPEND) begin
         if (at_capacity) begin
            cmd_data.kind   = CMD_NOP;
            cmd_data.status = STAT_FULL;
         end else begin
            cmd_data.kind   = CMD_APPEND;
            cmd_data.status = STAT_OK;
         end
      end else begin
         if (req_low_index > count_ff || req_high_index > count_ff) begin
            cmd_data.kind   = CMD_NOP;
            cmd_data.status = STAT_RANGE;
         end else begin
            cmd_data.kind   = CMD_QUERY;
            cmd_data.status = STAT_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count exceeds capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !grows |=> count_ff == $past(count_ff))
      else $error("element count changed without an append");

   a_no_grow_full: assert property (@(posedge clock) disable iff (reset)
      grows |-> !at_capacity)
      else $error("append accepted at capacity");

endmodule

// File: design/fwk_cmdq.sv
// Short command queue between the front end and the tree walker.
module fwk_cmdq import fwk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    not_empty
);

   cmd_type                entries_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0]  fill_ff;
   logic                   do_push, do_pop;

   assign full      = (fill_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMDQ_PTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + CMDQ_CNT_W'(1);
            2'b01:   fill_ff <= fill_ff - CMDQ_CNT_W'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue overfilled");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || full) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("command queue pointers disagree with fill level");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !not_empty |=> fill_ff <= CMDQ_CNT_W'(1))
      else $error("command queue fill moved wrong from empty");

endmodule

// File: design/fwk_back.sv
// Back end: walks the tree memory for appends and range queries and holds the result beat.
module fwk_back import fwk_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd_head,
   input  logic                     cmd_valid,
   output logic                     cmd_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [DATA_W-1:0] rsp_range_sum,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [CNT_W-1:0]         rsp_element_count
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   logic [DATA_W-1:0] tree_mem [CAPACITY];

   state_type         state_ff, state_in;
   cmd_kind_type      kind_ff, kind_in;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  cursor_ff, cursor_in;
   logic [CNT_W-1:0]  floor_ff, floor_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic              second_ff, second_in;
   logic              phase_sub_ff, phase_sub_in;
   logic              pend_ff, pend_in;
   logic              pend_sub_ff, pend_sub_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] acc_now;
   logic [DATA_W-1:0] rdata_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_taken;
   logic              rsp_room;
   logic [CNT_W-1:0]  node_num;

   assign rsp_empty         = !rsp_valid_ff;
   assign rsp_range_sum     = rsp_sum_ff;
   assign rsp_status        = rsp_stat_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_taken         = rsp_pop && rsp_valid_ff;
   assign rsp_room          = !rsp_valid_ff || rsp_taken;

   // The read issued last cycle lands now; fold it into the running sum.
   always_comb begin
      acc_now = acc_ff;
      if (pend_ff) begin
         acc_now = pend_sub_ff ? acc_ff - rdata_ff : acc_ff + rdata_ff;
      end
   end

   assign node_num = {{(CNT_W-ADDR_W){1'b0}}, cmd_head.slot} + CNT_W'(1);
   assign rd_addr  = ADDR_W'(cursor_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      cursor_in    = cursor_ff;
      floor_in     = floor_ff;
      lo_in        = lo_ff;
      second_in    = second_ff;
      phase_sub_in = phase_sub_ff;
      pend_in      = 1'b0;
      pend_sub_in  = pend_sub_ff;
      acc_in       = acc_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      cmd_pop      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_taken;
      rsp_sum_in   = rsp_sum_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop      = 1'b1;
               kind_in      = cmd_head.kind;
               status_in    = cmd_head.status;
               count_in     = cmd_head.count;
               slot_in      = cmd_head.slot;
               lo_in        = cmd_head.lo_index;
               phase_sub_in = 1'b0;
               if (cmd_head.kind == CMD_APPEND) begin
                  // Children of node n are n-1, stepping down by lowbit, above n-lowbit(n).
                  acc_in    = cmd_head.value;
                  cursor_in = node_num - CNT_W'(1);
                  floor_in  = node_num - lowbit(node_num);
                  second_in = 1'b0;
                  state_in  = S_WALK;
               end else if (cmd_head.kind == CMD_QUERY) begin
                  acc_in    = '0;
                  cursor_in = cmd_head.hi_index;
                  floor_in  = '0;
                  second_in = 1'b1;
                  state_in  = S_WALK;
               end else begin
                  acc_in    = '0;
                  state_in  = S_DONE;
               end
            end
         end
         S_WALK: begin
            acc_in = acc_now;
            if (cursor_ff > floor_ff) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_sub_in = phase_sub_ff;
               cursor_in   = cursor_ff - lowbit(cursor_ff);
            end else if (second_ff) begin
               // Upper prefix done; now subtract the lower prefix.
               cursor_in    = lo_ff;
               second_in    = 1'b0;
               phase_sub_in = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_room) begin
               wr_en        = (kind_ff == CMD_APPEND);
               rsp_valid_in = 1'b1;
               rsp_sum_in   = (kind_ff == CMD_QUERY) ? acc_ff : '0;
               rsp_stat_in  = status_ff;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= tree_mem[rd_addr];
      end
      if (wr_en) begin
         tree_mem[slot_ff] <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      status_ff    <= status_in;
      count_ff     <= count_in;
      slot_ff      <= slot_in;
      cursor_ff    <= cursor_in;
      floor_ff     <= floor_in;
      lo_ff        <= lo_in;
      second_ff    <= second_in;
      phase_sub_ff <= phase_sub_in;
      pend_sub_ff  <= pend_sub_in;
      acc_ff       <= acc_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> state_ff == S_WALK)
      else $error("tree read issued outside the walk");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> !pend_ff)
      else $error("result formed with a read still in flight");

   a_write_append: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_DONE && kind_ff == CMD_APPEND)
      else $error("tree written for a non-append item");

   a_pend_follows_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> pend_ff)
      else $error("issued read was not folded into the sum");

endmodule
